>>> hdl/owm_pkg.sv
// Shared types and constants for the one-wire bus master.
// Used by the interfaces, the configuration registers, the front end and the back end.
package owm_pkg;

  localparam int FUNC_W = 3;
  localparam int DATA_W = 8;
  localparam int CFG_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int BIT_IDX_W = 3;
  localparam int BITS_PER_BYTE = 8;

  // Command codes carried in func
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 3'd0,
    FUNC_RESET = 3'd1,
    FUNC_WBIT  = 3'd2,
    FUNC_RBIT  = 3'd3,
    FUNC_WBYTE = 3'd4,
    FUNC_RBYTE = 3'd5,
    FUNC_RSV6  = 3'd6,
    FUNC_RSV7  = 3'd7
  } func_t;

  // Timing register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_SLOT_START    = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_READ_SAMPLE   = 3'd5,
    REG_READ_TAIL     = 3'd6,
    REG_NONE          = 3'd7
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RESET_LOW_DEF     = 10'd500;
  localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF = 10'd70;
  localparam logic [CFG_W-1:0] RESET_TAIL_DEF    = 10'd500;
  localparam logic [CFG_W-1:0] SLOT_START_DEF    = 10'd5;
  localparam logic [CFG_W-1:0] WRITE_HOLD_DEF    = 10'd60;
  localparam logic [CFG_W-1:0] READ_SAMPLE_DEF   = 10'd15;
  localparam logic [CFG_W-1:0] READ_TAIL_DEF     = 10'd45;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] presence_wait;
    logic [CFG_W-1:0] reset_tail;
    logic [CFG_W-1:0] slot_start;
    logic [CFG_W-1:0] write_hold;
    logic [CFG_W-1:0] read_sample;
    logic [CFG_W-1:0] read_tail;
  } timing_t;

  // Classification made by the front end
  typedef enum logic [2:0] {
    KIND_TICK  = 3'b001,
    KIND_START = 3'b010,
    KIND_BAD   = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] data;
    logic              bus_level;
  } entry_t;

  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_RST_LOW    = 8'b0000_0010,
    PH_RST_WAIT   = 8'b0000_0100,
    PH_RST_TAIL   = 8'b0000_1000,
    PH_SLOT_START = 8'b0001_0000,
    PH_WR_HOLD    = 8'b0010_0000,
    PH_RD_WAIT    = 8'b0100_0000,
    PH_RD_TAIL    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              no_presence;
    logic [DATA_W-1:0] read_data;
    logic              rejected;
  } result_t;

endpackage

>>> hdl/owm_if.sv
// Handshake channels of the one-wire bus master: commands in, results out.
// Field widths come from owm_pkg.
interface owm_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [owm_pkg::FUNC_W-1:0] func;
  logic [owm_pkg::DATA_W-1:0] data;
  logic                       bus_level;

  modport source(output valid, func, data, bus_level, input ready);
  modport sink(input valid, func, data, bus_level, output ready);
endinterface

interface owm_res_if;
  logic                       valid;
  logic                       ready;
  logic                       drive_low;
  logic                       busy_res;
  logic                       done_res;
  logic                       no_presence;
  logic [owm_pkg::DATA_W-1:0] read_data;
  logic                       rejected;

  modport source(output valid, drive_low, busy_res, done_res, no_presence, read_data,
                 rejected, input ready);
  modport sink(input valid, drive_low, busy_res, done_res, no_presence, read_data,
               rejected, output ready);
endinterface

>>> hdl/owm_cfg.sv
// Timing register file of the one-wire bus master.
// Depends on owm_pkg for register indexes, defaults and the timing struct.
module owm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data,
  output owm_pkg::timing_t              timing
);

  owm_pkg::timing_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.reset_low     <= owm_pkg::RESET_LOW_DEF;
      regs.presence_wait <= owm_pkg::PRESENCE_WAIT_DEF;
      regs.reset_tail    <= owm_pkg::RESET_TAIL_DEF;
      regs.slot_start    <= owm_pkg::SLOT_START_DEF;
      regs.write_hold    <= owm_pkg::WRITE_HOLD_DEF;
      regs.read_sample   <= owm_pkg::READ_SAMPLE_DEF;
      regs.read_tail     <= owm_pkg::READ_TAIL_DEF;
    end else if (cfg_we) begin
      case (owm_pkg::reg_idx_t'(cfg_index))
        owm_pkg::REG_RESET_LOW:     regs.reset_low     <= cfg_data;
        owm_pkg::REG_PRESENCE_WAIT: regs.presence_wait <= cfg_data;
        owm_pkg::REG_RESET_TAIL:    regs.reset_tail    <= cfg_data;
        owm_pkg::REG_SLOT_START:    regs.slot_start    <= cfg_data;
        owm_pkg::REG_WRITE_HOLD:    regs.write_hold    <= cfg_data;
        owm_pkg::REG_READ_SAMPLE:   regs.read_sample   <= cfg_data;
        owm_pkg::REG_READ_TAIL:     regs.read_tail     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign timing = regs;

endmodule

>>> hdl/owm_front.sv
// Front end: accepts command transactions, classifies func and queues them.
// Depends on owm_pkg and owm_cmd_if; feeds owm_back through a two-entry queue.
module owm_front (
  input  logic             clk,
  input  logic             rst,
  owm_cmd_if.sink          cmd,
  output logic             q_valid,
  output owm_pkg::entry_t  q_entry,
  input  logic             q_pop
);

  localparam int DEPTH = 2;

  owm_pkg::entry_t slots [DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  owm_pkg::entry_t incoming;

  always_comb begin
    incoming.func      = cmd.func;
    incoming.data      = cmd.data;
    incoming.bus_level = cmd.bus_level;
    case (owm_pkg::func_t'(cmd.func))
      owm_pkg::FUNC_TICK: incoming.kind = owm_pkg::KIND_TICK;
      owm_pkg::FUNC_RESET, owm_pkg::FUNC_WBIT, owm_pkg::FUNC_RBIT,
      owm_pkg::FUNC_WBYTE, owm_pkg::FUNC_RBYTE: incoming.kind = owm_pkg::KIND_START;
      default: incoming.kind = owm_pkg::KIND_BAD;
    endcase
  end

  assign cmd.ready = (count != 2'(DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_entry   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/owm_back.sv
// Back end: runs the bus timing state machine one queued item per cycle while its
// result output register is free or being emptied. Depends on owm_pkg and owm_res_if.
module owm_back #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  owm_pkg::timing_t timing,
  input  logic             q_valid,
  input  owm_pkg::entry_t  q_entry,
  output logic             q_pop,
  owm_res_if.source        res
);

  localparam int CFG_W = owm_pkg::CFG_W;
  localparam int LW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [LW-1:0] CMAX = LW'((1 << COUNT_WIDTH) - 1);
  localparam logic [owm_pkg::BIT_IDX_W-1:0] LAST_BIT =
    owm_pkg::BIT_IDX_W'(owm_pkg::BITS_PER_BYTE - 1);

  owm_pkg::phase_t                phase, phase_next;
  logic [COUNT_WIDTH-1:0]         tick_count, tick_count_next;
  logic [owm_pkg::FUNC_W-1:0]     operation, operation_next;
  logic [owm_pkg::BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [owm_pkg::DATA_W-1:0]     shift_byte, shift_byte_next;
  logic                           presence_bit, presence_bit_next;

  logic                           out_valid;
  owm_pkg::result_t               out_res;
  owm_pkg::result_t               res_next;

  logic                           is_write, is_byte, is_read;
  logic [CFG_W-1:0]               len_raw;
  logic [LW-1:0]                  len_ext, len_clip;
  logic [LW:0]                    count_inc;
  logic                           phase_end;
  logic                           finished;

  assign is_write = (operation == owm_pkg::FUNC_WBIT) || (operation == owm_pkg::FUNC_WBYTE);
  assign is_byte  = (operation == owm_pkg::FUNC_WBYTE) || (operation == owm_pkg::FUNC_RBYTE);
  assign is_read  = (operation == owm_pkg::FUNC_RBIT) || (operation == owm_pkg::FUNC_RBYTE);

  always_comb begin
    case (phase)
      owm_pkg::PH_RST_LOW:    len_raw = timing.reset_low;
      owm_pkg::PH_RST_WAIT:   len_raw = timing.presence_wait;
      owm_pkg::PH_RST_TAIL:   len_raw = timing.reset_tail;
      owm_pkg::PH_SLOT_START: len_raw = is_write ? timing.slot_start : CFG_W'(1);
      owm_pkg::PH_WR_HOLD:    len_raw = timing.write_hold;
      owm_pkg::PH_RD_WAIT:    len_raw = timing.read_sample;
      owm_pkg::PH_RD_TAIL:    len_raw = timing.read_tail;
      default:                len_raw = CFG_W'(1);
    endcase
  end

  // Clip lengths the counter cannot reach
  assign len_ext   = LW'(len_raw);
  assign len_clip  = (len_ext > CMAX) ? CMAX : len_ext;
  assign count_inc = (LW + 1)'(tick_count) + (LW + 1)'(1);
  assign phase_end = (count_inc >= {1'b0, len_clip});

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    operation_next    = operation;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    presence_bit_next = presence_bit;
    finished          = 1'b0;
    res_next.rejected  = 1'b0;
    res_next.read_data = '0;

    case (q_entry.kind)
      owm_pkg::KIND_TICK: begin
        if (phase != owm_pkg::PH_IDLE) begin
          if (phase_end) begin
            tick_count_next = '0;
            case (phase)
              owm_pkg::PH_RST_LOW:  phase_next = owm_pkg::PH_RST_WAIT;
              owm_pkg::PH_RST_WAIT: begin
                presence_bit_next = q_entry.bus_level;
                phase_next        = owm_pkg::PH_RST_TAIL;
              end
              owm_pkg::PH_RST_TAIL: finished = 1'b1;
              owm_pkg::PH_SLOT_START:
                phase_next = is_write ? owm_pkg::PH_WR_HOLD : owm_pkg::PH_RD_WAIT;
              owm_pkg::PH_RD_WAIT: begin
                shift_byte_next[bit_index] = shift_byte[bit_index] | q_entry.bus_level;
                phase_next                 = owm_pkg::PH_RD_TAIL;
              end
              default: begin
                // End of a write hold or a read tail: advance to the next bit of a byte, or finish
                if (is_byte && (bit_index < LAST_BIT)) begin
                  bit_index_next = bit_index + owm_pkg::BIT_IDX_W'(1);
                  phase_next     = owm_pkg::PH_SLOT_START;
                end else begin
                  finished = 1'b1;
                end
              end
            endcase
            if (finished) begin
              if (is_read) begin
                res_next.read_data = shift_byte_next;
              end
              phase_next     = owm_pkg::PH_IDLE;
              operation_next = '0;
            end
          end else begin
            tick_count_next = tick_count + COUNT_WIDTH'(1);
          end
        end
      end
      owm_pkg::KIND_START: begin
        if (phase == owm_pkg::PH_IDLE) begin
          operation_next  = q_entry.func;
          tick_count_next = '0;
          bit_index_next  = '0;
          case (owm_pkg::func_t'(q_entry.func))
            owm_pkg::FUNC_WBIT:  shift_byte_next = {7'd0, q_entry.data[0]};
            owm_pkg::FUNC_WBYTE: shift_byte_next = q_entry.data;
            default:             shift_byte_next = '0;
          endcase
          phase_next = (q_entry.func == owm_pkg::FUNC_RESET) ? owm_pkg::PH_RST_LOW
                                                             : owm_pkg::PH_SLOT_START;
        end else begin
          res_next.rejected = 1'b1;
        end
      end
      default: res_next.rejected = 1'b1;
    endcase

    case (phase_next)
      owm_pkg::PH_RST_LOW, owm_pkg::PH_SLOT_START: res_next.drive_low = 1'b1;
      owm_pkg::PH_WR_HOLD: res_next.drive_low = ~shift_byte_next[bit_index_next];
      default:             res_next.drive_low = 1'b0;
    endcase
    res_next.busy_res    = (phase_next != owm_pkg::PH_IDLE);
    res_next.done_res    = finished;
    res_next.no_presence = presence_bit_next;
  end

  // Step only when the output register is free or being emptied
  assign q_pop = q_valid && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= owm_pkg::PH_IDLE;
      tick_count   <= '0;
      operation    <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      presence_bit <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        operation    <= operation_next;
        bit_index    <= bit_index_next;
        shift_byte   <= shift_byte_next;
        presence_bit <= presence_bit_next;
        out_valid    <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res <= res_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.drive_low   = out_res.drive_low;
  assign res.busy_res    = out_res.busy_res;
  assign res.done_res    = out_res.done_res;
  assign res.no_presence = out_res.no_presence;
  assign res.read_data   = out_res.read_data;
  assign res.rejected    = out_res.rejected;

endmodule

>>> hdl/one_wire_bus_master.sv
// One-wire bus master: one command or tick transaction per cycle while neither the queue
// nor the output register holds the flow, one result per transaction. A result can be taken
// once its transaction has passed through the queue, then the output register; the timing
// state machine in the back end takes one step per transaction. Reset (synchronous) empties the queue
// and the output register, returns the machine to idle and loads the default timing registers.
module one_wire_bus_master #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  owm_cmd_if.sink                       cmd,
  owm_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);

  owm_pkg::timing_t timing;
  logic             q_valid;
  owm_pkg::entry_t  q_entry;
  logic             q_pop;

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  owm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  owm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .timing  (timing),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking bench for one_wire_bus_master: drives command and tick transactions,
// predicts every result with its own line-timing model and checks the results in order.
// Depends on owm_pkg, owm_cmd_if and owm_res_if from the RTL.
module tb_top;

  localparam int HALF_PERIOD  = 6;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    owm_pkg::func_t             func;
    logic [owm_pkg::DATA_W-1:0] data;
    logic                       bus_level;
  } cmd_item_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [owm_pkg::CFG_W-1:0]     cfg_data;

  owm_cmd_if cmd_ch();
  owm_res_if res_ch();

  one_wire_bus_master uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cmd_item_t         cmd_q[$];
  owm_pkg::result_t  line_q[$];
  int                errors;
  bit                calm;
  bit                cmd_taken;
  int                send_gap;
  int                recv_hold;

  // Line model state
  owm_pkg::timing_t           tm;
  owm_pkg::phase_t            ph;
  logic [owm_pkg::CFG_W-1:0]  ph_ticks;
  owm_pkg::func_t             op;
  logic [2:0]                 bit_sel;
  logic [owm_pkg::DATA_W-1:0] shreg;
  logic                       presence;

  function automatic owm_pkg::result_t line_step(cmd_item_t it);
    owm_pkg::result_t r;
    int               len;
    bit               fin;
    bit               wr;
    r = '0;
    fin = 1'b0;
    wr = (op == owm_pkg::FUNC_WBIT) || (op == owm_pkg::FUNC_WBYTE);
    if (it.func == owm_pkg::FUNC_TICK) begin
      if (ph != owm_pkg::PH_IDLE) begin
        case (ph)
          owm_pkg::PH_RST_LOW:    len = int'(tm.reset_low);
          owm_pkg::PH_RST_WAIT:   len = int'(tm.presence_wait);
          owm_pkg::PH_RST_TAIL:   len = int'(tm.reset_tail);
          owm_pkg::PH_SLOT_START: len = wr ? int'(tm.slot_start) : 1;
          owm_pkg::PH_WR_HOLD:    len = int'(tm.write_hold);
          owm_pkg::PH_RD_WAIT:    len = int'(tm.read_sample);
          default:                len = int'(tm.read_tail);
        endcase
        // a zero length still takes one tick
        if (ph_ticks + 1 >= len) begin
          ph_ticks = '0;
          case (ph)
            owm_pkg::PH_RST_LOW: ph = owm_pkg::PH_RST_WAIT;
            owm_pkg::PH_RST_WAIT: begin
              presence = it.bus_level;
              ph = owm_pkg::PH_RST_TAIL;
            end
            owm_pkg::PH_RST_TAIL: fin = 1'b1;
            owm_pkg::PH_SLOT_START: ph = wr ? owm_pkg::PH_WR_HOLD : owm_pkg::PH_RD_WAIT;
            owm_pkg::PH_RD_WAIT: begin
              shreg[bit_sel] = shreg[bit_sel] | it.bus_level;
              ph = owm_pkg::PH_RD_TAIL;
            end
            default: begin
              // close the slot; byte operations open the next one back to back
              if ((op == owm_pkg::FUNC_WBYTE || op == owm_pkg::FUNC_RBYTE) &&
                  bit_sel < owm_pkg::BITS_PER_BYTE - 1) begin
                bit_sel = bit_sel + 1'b1;
                ph = owm_pkg::PH_SLOT_START;
              end else begin
                fin = 1'b1;
              end
            end
          endcase
          if (fin) begin
            r.done_res = 1'b1;
            if (op == owm_pkg::FUNC_RBIT || op == owm_pkg::FUNC_RBYTE) r.read_data = shreg;
            ph = owm_pkg::PH_IDLE;
            op = owm_pkg::FUNC_TICK;
          end
        end else begin
          ph_ticks = ph_ticks + 1'b1;
        end
      end
    end else if (it.func <= owm_pkg::FUNC_RBYTE && ph == owm_pkg::PH_IDLE) begin
      op = it.func;
      ph_ticks = '0;
      bit_sel = '0;
      case (it.func)
        owm_pkg::FUNC_WBIT:  shreg = {7'b0, it.data[0]};
        owm_pkg::FUNC_WBYTE: shreg = it.data;
        default:             shreg = '0;
      endcase
      ph = (it.func == owm_pkg::FUNC_RESET) ? owm_pkg::PH_RST_LOW : owm_pkg::PH_SLOT_START;
    end else begin
      r.rejected = 1'b1;
    end
    r.drive_low = (ph == owm_pkg::PH_RST_LOW) || (ph == owm_pkg::PH_SLOT_START) ||
                  (ph == owm_pkg::PH_WR_HOLD && !shreg[bit_sel]);
    r.busy_res = (ph != owm_pkg::PH_IDLE);
    r.no_presence = presence;
    return r;
  endfunction

  function automatic string res_text(owm_pkg::result_t r);
    return $sformatf("drive_low=%b busy=%b done=%b no_presence=%b read_data=%02h rejected=%b",
                     r.drive_low, r.busy_res, r.done_res, r.no_presence, r.read_data,
                     r.rejected);
  endfunction

  task automatic push_ticks(int n);
    cmd_item_t it;
    repeat (n) begin
      it.func = owm_pkg::FUNC_TICK;
      it.data = owm_pkg::DATA_W'($urandom);
      it.bus_level = 1'($urandom);
      cmd_q.push_back(it);
    end
  endtask

  task automatic add_cmd(owm_pkg::func_t f, logic [owm_pkg::DATA_W-1:0] d);
    cmd_item_t it;
    it.func = f;
    it.data = d;
    it.bus_level = 1'($urandom);
    cmd_q.push_back(it);
  endtask

  task automatic write_reg(owm_pkg::reg_idx_t idx, logic [owm_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      owm_pkg::REG_RESET_LOW:     tm.reset_low = val;
      owm_pkg::REG_PRESENCE_WAIT: tm.presence_wait = val;
      owm_pkg::REG_RESET_TAIL:    tm.reset_tail = val;
      owm_pkg::REG_SLOT_START:    tm.slot_start = val;
      owm_pkg::REG_WRITE_HOLD:    tm.write_hold = val;
      owm_pkg::REG_READ_SAMPLE:   tm.read_sample = val;
      owm_pkg::REG_READ_TAIL:     tm.read_tail = val;
      default: ;
    endcase
  endtask

  task automatic program_timing(owm_pkg::timing_t t);
    write_reg(owm_pkg::REG_RESET_LOW, t.reset_low);
    write_reg(owm_pkg::REG_PRESENCE_WAIT, t.presence_wait);
    write_reg(owm_pkg::REG_RESET_TAIL, t.reset_tail);
    write_reg(owm_pkg::REG_SLOT_START, t.slot_start);
    write_reg(owm_pkg::REG_WRITE_HOLD, t.write_hold);
    write_reg(owm_pkg::REG_READ_SAMPLE, t.read_sample);
    write_reg(owm_pkg::REG_READ_TAIL, t.read_tail);
    // no register behind this index: the write must leave the timing alone
    write_reg(owm_pkg::REG_NONE, owm_pkg::CFG_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain all traffic, then tick the line until the model says idle
  task automatic settle();
    bit more;
    do begin
      // look just after the edge so the driver has already moved
      do begin
        @(negedge clk);
        #1;
      end while (cmd_q.size() > 0 || cmd_ch.valid || line_q.size() > 0);
      repeat (4) @(negedge clk);
      more = (ph != owm_pkg::PH_IDLE);
      if (more) push_ticks(16);
    end while (more);
  endtask

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 13);
        cmd_ch.valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        it = cmd_q.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= it.func;
        cmd_ch.data <= it.data;
        cmd_ch.bus_level <= it.bus_level;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_hold = 0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_hold = $urandom_range(0, 13);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    owm_pkg::result_t got;
    owm_pkg::result_t want;
    cmd_item_t        it;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      // check before predicting so a stray result cannot meet this edge's expectation
      if (res_ch.valid && res_ch.ready) begin
        got.drive_low = res_ch.drive_low;
        got.busy_res = res_ch.busy_res;
        got.done_res = res_ch.done_res;
        got.no_presence = res_ch.no_presence;
        got.read_data = res_ch.read_data;
        got.rejected = res_ch.rejected;
        if (line_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) $display("unexpected result: %s", res_text(got));
        end else begin
          want = line_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       res_text(want), res_text(got));
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        it.func = owm_pkg::func_t'(cmd_ch.func);
        it.data = cmd_ch.data;
        it.bus_level = cmd_ch.bus_level;
        line_q.push_back(line_step(it));
      end
    end
  end

  initial begin
    owm_pkg::timing_t t;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = owm_pkg::REG_NONE;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = owm_pkg::FUNC_TICK;
    cmd_ch.data = '0;
    cmd_ch.bus_level = 1'b0;
    res_ch.ready = 1'b0;
    tm = {owm_pkg::RESET_LOW_DEF, owm_pkg::PRESENCE_WAIT_DEF, owm_pkg::RESET_TAIL_DEF,
          owm_pkg::SLOT_START_DEF, owm_pkg::WRITE_HOLD_DEF, owm_pkg::READ_SAMPLE_DEF,
          owm_pkg::READ_TAIL_DEF};
    ph = owm_pkg::PH_IDLE;
    ph_ticks = '0;
    op = owm_pkg::FUNC_TICK;
    bit_sel = '0;
    shreg = '0;
    presence = 1'b1;
    errors = 0;
    calm = 1'b0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // default timing: idle ticks, reserved codes, commands while busy
    push_ticks(2);
    add_cmd(owm_pkg::FUNC_RSV6, 8'h3C);
    add_cmd(owm_pkg::FUNC_RSV7, 8'hC3);
    add_cmd(owm_pkg::FUNC_WBIT, 8'hFE);
    push_ticks(1);
    add_cmd(owm_pkg::FUNC_WBYTE, 8'hFF);
    add_cmd(owm_pkg::FUNC_RESET, 8'h00);
    settle();
    add_cmd(owm_pkg::FUNC_RBIT, 8'h00);
    settle();

    // zero lengths: every phase lasts a single tick
    program_timing('0);
    add_cmd(owm_pkg::FUNC_WBYTE, 8'hA5);
    settle();
    add_cmd(owm_pkg::FUNC_RBYTE, 8'hFF);
    settle();
    add_cmd(owm_pkg::FUNC_RESET, 8'h00);
    settle();
    add_cmd(owm_pkg::FUNC_WBIT, 8'h01);
    settle();

    // random traffic, mostly short timings so operations complete often
    for (int p = 0; p < 5; p++) begin
      for (int f = 0; f < 7; f++)
        t[f*owm_pkg::CFG_W +: owm_pkg::CFG_W] =
          owm_pkg::CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 3));
      program_timing(t);
      if (p == 4) calm = 1'b1;
      repeat (150) begin
        if ($urandom_range(0, 99) < 7)
          add_cmd(owm_pkg::func_t'($urandom_range(owm_pkg::FUNC_RESET, owm_pkg::FUNC_RSV7)),
                  owm_pkg::DATA_W'($urandom));
        else
          push_ticks(1);
      end
      settle();
    end

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
